FILE: sv/mffd_pkg.sv
// ----------------------------------------------------------------------------
// mffd_pkg
// Shared types and constants for the motor feedback frame decoder.
// ----------------------------------------------------------------------------
package mffd_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int ID_W        = 11;
    localparam int PAYLOAD_W   = 64;
    localparam int ENC_W       = 13;
    localparam int TURN_W      = 16;
    localparam int ANGLE_W     = 25;
    localparam int INDEX_W     = 3;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd513;

    localparam logic signed [ENC_W:0] JUMP_LIMIT_POS = 14'sd4096;
    localparam logic signed [ENC_W:0] JUMP_LIMIT_NEG = -14'sd4096;
    localparam int DEG_PER_TURN = 360;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_ANGLE
    } t_state;

    typedef struct packed {
        logic [ENC_W-1:0]  position;
        logic [TURN_W-1:0] turns;
    } t_entry;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

FILE: sv/mffd_state_ram.sv
// ----------------------------------------------------------------------------
// mffd_state_ram
// Per-motor state memory with a registered read; entries read as zero
// until first written.
// ----------------------------------------------------------------------------
module mffd_state_ram #(
    parameter int MOTOR_COUNT = mffd_pkg::MOTOR_COUNT,
    parameter int ADDR_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mffd_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  mffd_pkg::t_entry     i_wr_data,
    output mffd_pkg::t_entry     o_rd_data
);

    mffd_pkg::t_entry r_mem [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_vld;
    mffd_pkg::t_entry r_rd_data;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: sv/motor_feedback_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder_top
// Decodes motor feedback frames and unwraps the encoder into turns and angle.
//
// Input channel (i_valid / o_stall) carries one frame: identifier and eight
// payload bytes. Frames whose identifier lies in the window base_id ..
// base_id + MOTOR_COUNT - 1 give one result beat on the output channel
// (o_valid / i_stall); other frames are dropped.
// A matching frame is handled in order: accept and read the motor's state,
// update and write back turn count and position, then form the angle into
// the output register. A new frame is accepted only once the state machine
// is idle again, after the angle step, so frames do not overlap; the
// read-modify-write of the state memory sets this.
// The output register holds a finished result while i_stall is high; the
// next frame may be accepted meanwhile, and it waits in its angle cycle
// until the output register drains.
// Reset returns base_id to 513 and all motor state to zero; no clearing
// pass is needed. The configuration channel is always ready.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_top #(
    parameter int MOTOR_COUNT = mffd_pkg::MOTOR_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mffd_pkg::ID_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mffd_pkg::ID_W-1:0]           i_frame_id,
    input  logic [mffd_pkg::PAYLOAD_W-1:0]      i_payload,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mffd_pkg::INDEX_W-1:0]        o_motor_index,
    output logic [mffd_pkg::ENC_W-1:0]          o_encoder,
    output logic signed [15:0]                  o_speed,
    output logic signed [15:0]                  o_current,
    output logic [7:0]                          o_temperature,
    output logic signed [mffd_pkg::TURN_W-1:0]  o_turns,
    output logic signed [mffd_pkg::ANGLE_W-1:0] o_angle
);

    localparam int IDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int ENC_W   = mffd_pkg::ENC_W;
    localparam int TURN_W  = mffd_pkg::TURN_W;
    localparam int ANGLE_W = mffd_pkg::ANGLE_W;
    localparam int ID_W    = mffd_pkg::ID_W;
    localparam int PROD_W  = ENC_W + 9;

    mffd_pkg::t_state r_state, n_state;
    logic [ID_W-1:0] r_base;

    logic [IDX_W-1:0]  r_idx;
    logic [ENC_W-1:0]  r_enc;
    logic [15:0]       r_speed;
    logic [15:0]       r_current;
    logic [7:0]        r_temp;
    logic [TURN_W-1:0] r_turns;

    logic                            r_out_valid;
    logic [IDX_W-1:0]                r_out_idx;
    logic [ENC_W-1:0]                r_out_enc;
    logic [15:0]                     r_out_speed;
    logic [15:0]                     r_out_current;
    logic [7:0]                      r_out_temp;
    logic [TURN_W-1:0]               r_out_turns;
    logic [ANGLE_W-1:0]              r_out_angle;

    logic              w_accept;
    logic [ID_W:0]     w_rel;
    logic              w_hit;
    logic              w_load;
    logic              w_drain;
    mffd_pkg::t_mem_ctl w_ctl;
    mffd_pkg::t_entry  w_rd;
    mffd_pkg::t_entry  w_wr;
    logic signed [ENC_W:0] w_diff;
    logic [TURN_W-1:0] w_new_turns;
    logic signed [ANGLE_W-1:0] w_turn_deg;
    logic [PROD_W-1:0] w_enc_prod;
    logic [ANGLE_W-1:0] w_angle;

    assign w_accept = i_valid && !o_stall;
    assign w_rel    = {1'b0, i_frame_id} - {1'b0, r_base};
    assign w_hit    = !w_rel[ID_W] && (w_rel[ID_W-1:0] < ID_W'(MOTOR_COUNT));
    assign w_drain  = r_out_valid && !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mffd_pkg::ST_IDLE: begin
                if (w_accept && w_hit) begin
                    n_state = mffd_pkg::ST_UPDATE;
                end
            end
            mffd_pkg::ST_UPDATE: begin
                n_state = mffd_pkg::ST_ANGLE;
            end
            mffd_pkg::ST_ANGLE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = mffd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mffd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_stall  = 1'b1;
        w_ctl.rd = 1'b0;
        w_ctl.wr = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            mffd_pkg::ST_IDLE: begin
                o_stall  = 1'b0;
                w_ctl.rd = w_accept && w_hit;
            end
            mffd_pkg::ST_UPDATE: begin
                w_ctl.wr = 1'b1;
            end
            mffd_pkg::ST_ANGLE: begin
                w_load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mffd_pkg::ST_IDLE;
            r_base  <= mffd_pkg::BASE_ID_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    mffd_state_ram #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .ADDR_W      (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rel[IDX_W-1:0]),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr),
        .o_rd_data (w_rd)
    );

    // unwrap
    assign w_diff = $signed({1'b0, r_enc}) - $signed({1'b0, w_rd.position});

    always_comb begin
        w_new_turns = w_rd.turns;
        if (w_diff > mffd_pkg::JUMP_LIMIT_POS) begin
            w_new_turns = w_rd.turns - TURN_W'(1);
        end else if (w_diff < mffd_pkg::JUMP_LIMIT_NEG) begin
            w_new_turns = w_rd.turns + TURN_W'(1);
        end
    end

    assign w_wr.position = r_enc;
    assign w_wr.turns    = w_new_turns;

    // capture frame fields and updated turn count
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx     <= w_rel[IDX_W-1:0];
            r_enc     <= i_payload[48 +: ENC_W];
            r_speed   <= i_payload[47:32];
            r_current <= i_payload[31:16];
            r_temp    <= i_payload[15:8];
        end
        if (r_state == mffd_pkg::ST_UPDATE) begin
            r_turns <= w_new_turns;
        end
    end

    // angle
    assign w_turn_deg = $signed({{(ANGLE_W-TURN_W){r_turns[TURN_W-1]}}, r_turns})
                        * $signed(ANGLE_W'(mffd_pkg::DEG_PER_TURN));
    assign w_enc_prod = PROD_W'(r_enc) * PROD_W'(mffd_pkg::DEG_PER_TURN);
    assign w_angle    = w_turn_deg
                        + ANGLE_W'(w_enc_prod[PROD_W-1:ENC_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_drain) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx     <= r_idx;
            r_out_enc     <= r_enc;
            r_out_speed   <= r_speed;
            r_out_current <= r_current;
            r_out_temp    <= r_temp;
            r_out_turns   <= r_turns;
            r_out_angle   <= w_angle;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_index = mffd_pkg::INDEX_W'(r_out_idx);
    assign o_encoder     = r_out_enc;
    assign o_speed       = $signed(r_out_speed);
    assign o_current     = $signed(r_out_current);
    assign o_temperature = r_out_temp;
    assign o_turns       = $signed(r_out_turns);
    assign o_angle       = $signed(r_out_angle);

endmodule

FILE: sv/mffd_checker.sv
// ----------------------------------------------------------------------------
// mffd_checker
// Port-level checks for the motor feedback frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module mffd_checker #(
    parameter int MOTOR_COUNT = mffd_pkg::MOTOR_COUNT
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [mffd_pkg::INDEX_W-1:0]        o_motor_index,
    input logic [mffd_pkg::ENC_W-1:0]          o_encoder,
    input logic signed [mffd_pkg::TURN_W-1:0]  o_turns,
    input logic signed [mffd_pkg::ANGLE_W-1:0] o_angle
);

    localparam int PROD_W = mffd_pkg::ENC_W + 9;

    logic signed [mffd_pkg::ANGLE_W-1:0] w_exp_angle;
    logic [PROD_W-1:0] w_enc_prod;

    assign w_enc_prod  = PROD_W'(o_encoder) * PROD_W'(mffd_pkg::DEG_PER_TURN);
    assign w_exp_angle = $signed({{(mffd_pkg::ANGLE_W-mffd_pkg::TURN_W){o_turns[15]}},
                                  o_turns}) * $signed(mffd_pkg::ANGLE_W'(360))
                         + mffd_pkg::ANGLE_W'(w_enc_prod[PROD_W-1:mffd_pkg::ENC_W]);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle) && $stable(o_turns))
        else $error("stalled result changed");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle == w_exp_angle)
        else $error("angle does not match turns and encoder");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_motor_index) < MOTOR_COUNT)
        else $error("motor index outside window");

    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a frame in work");

endmodule

bind motor_feedback_frame_decoder_top mffd_checker #(
    .MOTOR_COUNT (MOTOR_COUNT)
) u_mffd_checker (.*);
